[hdl/relr_pkg.sv]
// Shared types and constants for the RELR relocation decoder.
// Depends on nothing; used by relr_addr_unit and relr_relocation_decoder_unit.
`default_nettype none

package relr_pkg;

	// Byte step between consecutive relocation slots
	localparam logic [63:0] WORD_BYTES  = 64'd8;
	// Address span covered by one bitmap word (63 slots)
	localparam logic [63:0] BITMAP_SPAN = 64'd504;

	// Result status codes, also the sticky error code
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_BASE  = 2'd1,
		ST_MISALIGN = 2'd2,
		ST_OVERFLOW = 2'd3
	} relr_status_t;

	// Increment chosen for the shared adder
	typedef enum logic {
		ADD_WORD = 1'b0,
		ADD_SPAN = 1'b1
	} relr_add_t;

	// Adder result: 64-bit sum plus carry out (overflow)
	typedef struct packed {
		logic        carry;
		logic [63:0] sum;
	} relr_sum_t;

endpackage

`default_nettype wire

[hdl/relr_addr_unit.sv]
// Shared 64-bit address adder: adds either one word (8) or one bitmap span (504).
// Depends on relr_pkg.
`default_nettype none

module relr_addr_unit import relr_pkg::*; (
	input  wire logic [63:0] op_a,
	input  wire relr_add_t   add_sel,
	output relr_sum_t        res
);

	logic [63:0] op_b;
	logic [64:0] full;

	// Select increment, add with carry out
	always_comb begin
		op_b = (add_sel == ADD_SPAN) ? BITMAP_SPAN : WORD_BYTES;
		full = {1'b0, op_a} + {1'b0, op_b};
		res.carry = full[64];
		res.sum   = full[63:0];
	end

endmodule

`default_nettype wire

[hdl/relr_relocation_decoder_unit.sv]
// RELR relocation decoder top level: input capture, decode, bitmap scan, output register.
// Depends on relr_pkg and relr_addr_unit.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  in      | in_valid/in_ready  | entry_word[63:0], table_start
//  out     | out_valid/out_ready| target_address[63:0], target_valid, status[1:0],
//          |                    | last_of_run
//
// Steps: an address word, an error word or an empty bitmap is captured, then decoded;
// a bitmap is also scanned up to its highest set bit (at most bit 63), one bitmap bit
// per cycle through the shared adder, except that a set bit waits for a free output.
// Reset clears base address, sticky error, state and output valid.
// A stalled output holds decode, or a scan step on a set bit, until out_ready frees it.
`default_nettype none

module relr_relocation_decoder_unit import relr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] entry_word,
	input  wire logic        table_start,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      target_address,
	output logic             target_valid,
	output logic [1:0]       status,
	output logic             last_of_run
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN
	} state_t;

	state_t       state_q;
	logic [63:0]  word_q;
	logic         tstart_q;
	logic [63:0]  base_q;
	relr_status_t err_q;
	logic [63:0]  addr_q;
	logic [62:0]  map_q;

	logic         out_valid_q;
	logic [63:0]  out_addr_q;
	logic         out_tv_q;
	relr_status_t out_st_q;
	logic         out_last_q;

	logic [63:0]  eff_base;
	relr_status_t eff_err;
	logic         out_free;
	logic [63:0]  add_a;
	relr_add_t    add_sel;
	relr_sum_t    add_res;

	relr_status_t dec_st;
	logic [63:0]  dec_base;
	logic [63:0]  dec_addr;
	logic         dec_tv;
	logic         dec_scan;
	logic         out_set;

	// Table start clears base and error before the word is decoded
	always_comb begin
		eff_base = tstart_q ? 64'd0 : base_q;
		eff_err  = tstart_q ? ST_OK : err_q;
		out_free = !out_valid_q || out_ready;
	end

	// Shared adder operand selection
	always_comb begin
		add_a   = addr_q;
		add_sel = ADD_WORD;
		if (state_q == S_DECODE) begin
			if (word_q[0]) begin
				add_a   = eff_base;
				add_sel = ADD_SPAN;
			end else begin
				add_a   = word_q;
			end
		end
	end

	relr_addr_unit u_addr (
		.op_a    (add_a),
		.add_sel (add_sel),
		.res     (add_res)
	);

	// Decode of the captured word: status, next base, single result or scan
	always_comb begin
		dec_st   = eff_err;
		dec_base = eff_base;
		dec_addr = '0;
		dec_tv   = 1'b0;
		dec_scan = 1'b0;
		if (eff_err != ST_OK) begin
			// sticky error, nothing else changes
		end else if (!word_q[0]) begin
			// address word
			if (word_q[2:1] != 2'b00) begin
				dec_st = ST_MISALIGN;
			end else if (add_res.carry) begin
				dec_st = ST_OVERFLOW;
			end else begin
				dec_base = add_res.sum;
				dec_addr = word_q;
				dec_tv   = 1'b1;
			end
		end else if (eff_base == 64'd0) begin
			dec_st = ST_NO_BASE;
		end else if (add_res.carry) begin
			dec_st = ST_OVERFLOW;
		end else begin
			// bitmap; an empty one gives a single non-target word
			dec_base = add_res.sum;
			dec_scan = (word_q[63:1] != 63'd0);
		end
	end

	// Output register loads a new word this cycle
	always_comb begin
		out_set = out_free && (((state_q == S_DECODE) && !dec_scan) ||
			((state_q == S_SCAN) && map_q[0]));
	end

	// Sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						word_q   <= entry_word;
						tstart_q <= table_start;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (out_free) begin
						base_q <= dec_base;
						err_q  <= dec_st;
						if (dec_scan) begin
							addr_q  <= eff_base;
							map_q   <= word_q[63:1];
							state_q <= S_SCAN;
						end else begin
							out_addr_q <= dec_addr;
							out_tv_q   <= dec_tv;
							out_st_q   <= dec_st;
							out_last_q <= 1'b1;
							state_q    <= S_IDLE;
						end
					end
				end
				S_SCAN: begin
					// one bitmap bit per cycle; a set bit waits for a free output slot
					if (!map_q[0] || out_free) begin
						addr_q <= add_res.sum;
						map_q  <= {1'b0, map_q[62:1]};
						if (map_q[0]) begin
							out_addr_q  <= addr_q;
							out_tv_q    <= 1'b1;
							out_st_q    <= ST_OK;
							out_last_q  <= (map_q[62:1] == 62'd0);
							if (map_q[62:1] == 62'd0) state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign target_address = out_addr_q;
	assign target_valid   = out_tv_q;
	assign status         = out_st_q;
	assign last_of_run    = out_last_q;

	// A target word always carries ok status
	a_target_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_tv_q |-> out_st_q == ST_OK)
		else $error("target word with error status");

	// Error words close their run
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q != ST_OK |-> out_last_q)
		else $error("error word not marked last");

	// Scan only runs with bits left
	a_scan_bits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> map_q != 63'd0)
		else $error("scan with empty bitmap");

	// Accepted word goes to decode next
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DECODE)
		else $error("accepted word not decoded");

	// Sticky error holds unless a decode step runs
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DECODE |=> $stable(err_q))
		else $error("error code changed outside decode");

endmodule

`default_nettype wire
